// ===== design/group_block_reverser_core_macros.svh =====
// Assertion helpers for the checker file of the group block reverser.
`ifndef GROUP_BLOCK_REVERSER_CORE_MACROS_SVH
`define GROUP_BLOCK_REVERSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GBR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gbr_pkg;

    localparam int VALUE_W         = 32;
    localparam int GROUP_SIZE_W    = 5;
    localparam int MAX_GROUP_DEF   = 16;
    localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RESET = 5'd2;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } seq_state_t;

    typedef enum logic {
        MODE_REVERSE,
        MODE_FORWARD
    } drain_mode_t;

    // Shift commands broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } chain_ctl_t;

endpackage

`default_nettype wire

// ===== design/gbr_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbr_cell
    import gbr_pkg::*;
(
    input  wire logic                      aclk,
    input  wire chain_ctl_t                ctl,
    input  wire logic signed [VALUE_W-1:0] from_left,
    input  wire logic signed [VALUE_W-1:0] from_right,
    output logic signed [VALUE_W-1:0]      q
);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    // A push moves data away from the head, a pop moves it toward the head.
    always_comb begin
        priority if (ctl.push) begin
            data_next = from_left;
        end else if (ctl.pop) begin
            data_next = from_right;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

`default_nettype wire

// ===== design/gbr_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbr_chain
    import gbr_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF,
    parameter int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
)
(
    input  wire logic                      aclk,
    input  wire chain_ctl_t                ctl,
    input  wire logic signed [VALUE_W-1:0] push_data,
    input  wire logic [IDX_W-1:0]          tap_idx,
    output logic signed [VALUE_W-1:0]      head,
    output logic signed [VALUE_W-1:0]      tap
);

    logic signed [VALUE_W-1:0] cell_q [MAX_GROUP];

    for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
        logic signed [VALUE_W-1:0] left_in;
        logic signed [VALUE_W-1:0] right_in;

        if (i == 0) begin : g_first
            assign left_in = push_data;
        end else begin : g_inner_l
            assign left_in = cell_q[i-1];
        end

        if (i == MAX_GROUP - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_inner_r
            assign right_in = cell_q[i+1];
        end

        gbr_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .from_left  (left_in),
            .from_right (right_in),
            .q          (cell_q[i])
        );
    end

    // The newest value always sits in the first cell.
    assign head = cell_q[0];
    assign tap  = cell_q[tap_idx];

endmodule

`default_nettype wire

// ===== design/gbr_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbr_seq
    import gbr_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF,
    parameter int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
    parameter int CNT_W     = $clog2(MAX_GROUP + 1)
)
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [GROUP_SIZE_W-1:0]   group_size,
    input  wire logic                      s_valid,
    input  wire logic                      s_last,
    output logic                           s_ready,
    output chain_ctl_t                     ctl,
    output logic [IDX_W-1:0]               tap_idx,
    input  wire logic signed [VALUE_W-1:0] head,
    input  wire logic signed [VALUE_W-1:0] tap,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [VALUE_W-1:0]      m_data,
    output logic                           m_last,
    output logic                           m_user
);

    localparam int CMP_W = (CNT_W > GROUP_SIZE_W) ? CNT_W : GROUP_SIZE_W;

    seq_state_t                state_reg,  state_next;
    drain_mode_t               mode_reg,   mode_next;
    logic [CNT_W-1:0]          held_reg,   held_next;
    logic [CNT_W-1:0]          remain_reg, remain_next;
    logic                      final_reg,  final_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [VALUE_W-1:0] m_data_reg,  m_data_next;
    logic                      m_last_reg,  m_last_next;
    logic                      m_user_reg,  m_user_next;

    logic [CMP_W-1:0] size_ext;
    logic [CNT_W-1:0] eff_k;
    logic [CNT_W-1:0] total;
    logic             accept;
    logic             step;
    logic             run_end;

    // Clamp the group size into one to MAX_GROUP.
    always_comb begin
        size_ext = CMP_W'(group_size);
        if (size_ext == '0) begin
            eff_k = CNT_W'(1);
        end else if (size_ext > CMP_W'(MAX_GROUP)) begin
            eff_k = CNT_W'(MAX_GROUP);
        end else begin
            eff_k = CNT_W'(size_ext);
        end
    end

    assign total   = held_reg + CNT_W'(1);
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign step    = (state_reg == ST_DRAIN) && (!m_valid_reg || m_ready);
    assign run_end = (remain_reg == CNT_W'(1));
    assign tap_idx = IDX_W'(remain_reg - CNT_W'(1));

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        held_next    = held_reg;
        remain_next  = remain_reg;
        final_next   = final_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        ctl.push     = 1'b0;
        ctl.pop      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ctl.push = 1'b1;
                    if (total >= eff_k) begin
                        state_next  = ST_DRAIN;
                        mode_next   = MODE_REVERSE;
                        remain_next = total;
                        final_next  = s_last;
                        held_next   = '0;
                    end else if (s_last) begin
                        state_next  = ST_DRAIN;
                        mode_next   = MODE_FORWARD;
                        remain_next = total;
                        final_next  = 1'b1;
                        held_next   = '0;
                    end else begin
                        held_next = total;
                    end
                end
            end
            ST_DRAIN: begin
                if (step) begin
                    m_valid_next = 1'b1;
                    m_last_next  = run_end;
                    m_user_next  = run_end && final_reg;
                    remain_next  = remain_reg - CNT_W'(1);
                    if (mode_reg == MODE_REVERSE) begin
                        m_data_next = head;
                        ctl.pop     = 1'b1;
                    end else begin
                        m_data_next = tap;
                    end
                    if (run_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_REVERSE;
            held_reg    <= '0;
            remain_reg  <= '0;
            final_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            held_reg    <= held_next;
            remain_reg  <= remain_next;
            final_reg   <= final_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;
    assign m_user  = m_user_reg;

endmodule

`default_nettype wire

// ===== design/group_block_reverser_core.sv =====
// Channel   Direction  Payload (lowest bit first)               Handshake
// s_        in         tdata: item_value[31:0]; tlast: end_of_list  s_tvalid / s_tready
// m_        out        tdata: out_value[31:0]; tlast: run_last;     m_tvalid / m_tready
//                      tuser: list_end
// cfg_      in         cfg_data: group_size[4:0]                    cfg_valid / cfg_ready
//
// An item that does not close a group is simply held. An item that closes a group of
// N values, or ends the list, is followed by a drain of those N values, one value per cycle
// while m_tready allows, paced by the single output register; intake is held off during the drain.
// Reset (aresetn low, synchronous) empties the group and sets the group size to two.
// A stall on m_tready freezes the drain; configuration is always accepted.
`timescale 1ns / 1ps
`default_nettype none

module group_block_reverser_core
    import gbr_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic signed [VALUE_W-1:0] s_tdata,   // [31:0] item_value
    input  wire logic                      s_tlast,   // end_of_list

    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic signed [VALUE_W-1:0]      m_tdata,   // [31:0] out_value
    output logic                           m_tlast,   // run_last
    output logic                           m_tuser,   // [0] list_end

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [GROUP_SIZE_W-1:0]   cfg_data   // [4:0] group_size
);

    localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W = $clog2(MAX_GROUP + 1);

    logic [GROUP_SIZE_W-1:0]   group_size_reg;
    logic [GROUP_SIZE_W-1:0]   group_size_next;
    chain_ctl_t                ctl;
    logic [IDX_W-1:0]          tap_idx;
    logic signed [VALUE_W-1:0] head;
    logic signed [VALUE_W-1:0] tap;

    // The group size register takes a write in any cycle. The value is clamped
    // inside the sequencer, so out-of-range codes are simply stored.
    assign cfg_ready       = 1'b1;
    assign group_size_next = (cfg_valid && cfg_ready) ? cfg_data : group_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_size_reg <= GROUP_SIZE_RESET;
        end else begin
            group_size_reg <= group_size_next;
        end
    end

    // The row of cells holds the current group, newest value in the first cell.
    // A push shifts every value one cell further down the row; a pop pulls them
    // back toward the head, which is how a completed group leaves newest first.
    gbr_chain #(
        .MAX_GROUP (MAX_GROUP),
        .IDX_W     (IDX_W)
    ) u_chain (
        .aclk      (aclk),
        .ctl       (ctl),
        .push_data (s_tdata),
        .tap_idx   (tap_idx),
        .head      (head),
        .tap       (tap)
    );

    // The sequencer counts held values, decides when a group is complete or a
    // partial tail must be flushed in arrival order, and drives the output register.
    gbr_seq #(
        .MAX_GROUP (MAX_GROUP),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .group_size (group_size_reg),
        .s_valid    (s_tvalid),
        .s_last     (s_tlast),
        .s_ready    (s_tready),
        .ctl        (ctl),
        .tap_idx    (tap_idx),
        .head       (head),
        .tap        (tap),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (m_tdata),
        .m_last     (m_tlast),
        .m_user     (m_tuser)
    );

endmodule

`default_nettype wire

// ===== design/gbr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "group_block_reverser_core_macros.svh"

module gbr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // The end of the whole list is always the end of a run.
    `GBR_ASSERT_NOW(a_list_end_is_run_end, aclk, aresetn, m_tvalid && m_tuser, m_tlast, "list end without run end")

    // While a run is still being delivered, no new item may enter.
    `GBR_ASSERT_NOW(a_no_intake_mid_run, aclk, aresetn, m_tvalid && !m_tlast, !s_tready, "intake open during a run")

    // The final item of a list always starts a drain.
    `GBR_ASSERT_NEXT(a_final_item_drains, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready, "final item did not start a drain")

    // A stalled result holds its value.
    `GBR_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind group_block_reverser_core gbr_checker u_gbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
